// ===== sv/srb_pkg.sv =====
// shared types and constants for the sound register block
package srb_pkg;

    // bus access codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // result command kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_TRIGGER = 2'd1;
    localparam logic [1:0] KIND_SWEEP   = 2'd2;

    // register addresses
    localparam logic [15:0] ADDR_SWEEP    = 16'hff10;
    localparam logic [15:0] ADDR_TONE0_LO = 16'hff10;
    localparam logic [15:0] ADDR_TONE0_HI = 16'hff14;
    localparam logic [15:0] ADDR_TONE1_LO = 16'hff16;
    localparam logic [15:0] ADDR_TONE1_HI = 16'hff19;
    localparam logic [15:0] ADDR_PLAIN_A  = 16'hff1a;
    localparam logic [15:0] ADDR_PLAIN_B  = 16'hff1e;
    localparam logic [15:0] ADDR_PLAIN_C  = 16'hff20;
    localparam logic [15:0] ADDR_PLAIN_D  = 16'hff23;
    localparam logic [15:0] ADDR_WAVE     = 16'hff30;
    localparam logic [15:0] ADDR_WAVE_END = 16'hff3f;

    // storage layout: tone slots, then plain slots, then wave bytes
    localparam int TONE_SLOTS  = 9;
    localparam int PLAIN_SLOTS = 9;
    localparam int WAVE_BASE   = TONE_SLOTS + PLAIN_SLOTS;

    // tone frequency math
    localparam int            QUO_W      = 18;
    localparam int            DIV_W      = 12;
    localparam logic [17:0]   FREQ_NUM   = 18'd131072;
    localparam logic [11:0]   FREQ_BASE  = 12'd2048;
    localparam logic [17:0]   FREQ_LIMIT = 18'd3000;
    localparam logic [6:0]    LEN_FULL   = 7'd64;

    typedef struct packed {
        logic        op;
        logic [15:0] address;
        logic [7:0]  value;
    } access_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        bad_address;
        logic [1:0]  update_kind;
        logic        channel;
        logic        length_on;
        logic [6:0]  length_left;
        logic [11:0] frequency_hz;
        logic [1:0]  duty_code;
        logic [3:0]  start_volume;
        logic        ramp_up;
        logic [2:0]  ramp_step;
        logic [2:0]  sweep_period;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_PAT,
        ST_VOL,
        ST_LO,
        ST_DIV,
        ST_HOLD
    } state_t;

endpackage

// ===== sv/srb_ram.sv =====
// generic single write port, single read port ram with registered read
module srb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 34
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/srb_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
module srb_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [srb_pkg::QUO_W-1:0]        dividend,
    input  logic [srb_pkg::DIV_W-1:0]        divisor,
    output logic                             done,
    output logic [srb_pkg::QUO_W-1:0]        quotient
);

    localparam int QW = srb_pkg::QUO_W;
    localparam int DW = srb_pkg::DIV_W;
    localparam int CW = $clog2(QW);

    logic [DW-1:0] rem_reg, rem_next;
    logic [QW-1:0] num_reg, num_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [DW-1:0] dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   rem_sh;
    logic          fits;

    // one shift and trial subtract per cycle
    always_comb
    begin
        rem_sh    = {rem_reg, num_reg[QW-1]};
        fits      = rem_sh >= {1'b0, dsr_reg};
        rem_next  = rem_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            num_next  = dividend;
            quo_next  = '0;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DW'(rem_sh - {1'b0, dsr_reg}) : rem_sh[DW-1:0];
            num_next = {num_reg[QW-2:0], 1'b0};
            quo_next = {quo_reg[QW-2:0], fits};
            cnt_next = CW'(cnt_reg + 1'b1);
            if (cnt_reg == CW'(QW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/sound_register_block_with_tone_trigger_core.sv =====
// sound register bank with tone trigger and sweep commands, top level
// a read passes through the read state to the hold state, a plain write goes straight to the hold state
// a trigger write does three ram reads then 18 divider steps
// one item is in work at a time; the next is accepted when the result leaves the sequencer
// the finished result waits in an output register while the next item is taken
// reset clears the sequencer and all entry valid bits, so every register reads as zero
module sound_register_block_with_tone_trigger_core #(
    parameter int WAVE_BYTES = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             access_valid,
    output logic             access_stall,
    input  srb_pkg::access_t access,
    output logic             result_valid,
    input  logic             result_stall,
    output srb_pkg::result_t result
);

    localparam int DEPTH = srb_pkg::WAVE_BASE + WAVE_BYTES;
    localparam int IW    = $clog2(DEPTH);

    localparam logic [IW-1:0] IDX_PAT0 = IW'(1);
    localparam logic [IW-1:0] IDX_PAT1 = IW'(5);

    srb_pkg::state_t  state_reg, state_next;
    srb_pkg::result_t res_reg, res_next;
    srb_pkg::result_t out_reg;
    logic             out_vld_reg, out_vld_next;
    logic [DEPTH-1:0] vld_reg, vld_next;
    logic             rd_vld_reg;
    logic [7:0]       hi_reg, hi_next;
    logic             chan_reg, chan_next;
    logic [7:0]       pat_reg, pat_next;
    logic [7:0]       vol_reg, vol_next;
    logic [IW-1:0]    base_reg, base_next;

    logic             accept;
    logic             hit;
    logic [IW-1:0]    idx;
    logic             we;
    logic [IW-1:0]    raddr;
    logic [7:0]       ram_rdata;
    logic [7:0]       rd_byte;
    logic             out_free;
    logic             div_start;
    logic [srb_pkg::DIV_W-1:0] div_dsr;
    logic             div_done;
    logic [srb_pkg::QUO_W-1:0] div_quo;

    assign accept   = access_valid && !access_stall;
    assign out_free = !out_vld_reg || !result_stall;

    // address decode into a storage slot
    always_comb
    begin
        hit = 1'b0;
        idx = '0;
        if (access.address >= srb_pkg::ADDR_TONE0_LO && access.address <= srb_pkg::ADDR_TONE0_HI)
        begin
            hit = 1'b1;
            idx = IW'(access.address[7:0] - 8'h10);
        end
        else if (access.address >= srb_pkg::ADDR_TONE1_LO
                 && access.address <= srb_pkg::ADDR_TONE1_HI)
        begin
            hit = 1'b1;
            idx = IW'(access.address[7:0] - 8'h11);
        end
        else if (access.address >= srb_pkg::ADDR_PLAIN_A
                 && access.address <= srb_pkg::ADDR_PLAIN_B)
        begin
            hit = 1'b1;
            idx = IW'(access.address[7:0] - 8'h11);
        end
        else if (access.address >= srb_pkg::ADDR_PLAIN_C
                 && access.address <= srb_pkg::ADDR_PLAIN_D)
        begin
            hit = 1'b1;
            idx = IW'(access.address[7:0] - 8'h12);
        end
        else if (access.address >= srb_pkg::ADDR_WAVE
                 && {1'b0, access.address} < 17'(srb_pkg::ADDR_WAVE) + 17'(WAVE_BYTES)
                 && access.address <= srb_pkg::ADDR_WAVE_END)
        begin
            hit = 1'b1;
            idx = IW'(access.address[7:0] - 8'h1e);
        end
    end

    // never-written entries read as zero
    assign rd_byte = rd_vld_reg ? ram_rdata : 8'h00;

    // sequencer: next state, ram control and result build
    always_comb
    begin
        state_next   = state_reg;
        res_next     = res_reg;
        hi_next      = hi_reg;
        chan_next    = chan_reg;
        pat_next     = pat_reg;
        vol_next     = vol_reg;
        base_next    = base_reg;
        vld_next     = vld_reg;
        out_vld_next = out_vld_reg && result_stall;
        access_stall = state_reg != srb_pkg::ST_IDLE;
        we           = 1'b0;
        raddr        = idx;
        div_start    = 1'b0;
        div_dsr      = srb_pkg::FREQ_BASE - {1'b0, hi_reg[2:0], rd_byte};
        case (state_reg)
            srb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_next   = '0;
                    state_next = srb_pkg::ST_HOLD;
                    if (!hit)
                    begin
                        res_next.bad_address = 1'b1;
                    end
                    else if (access.op == srb_pkg::OP_READ)
                    begin
                        state_next = srb_pkg::ST_READ;
                    end
                    else
                    begin
                        we           = 1'b1;
                        vld_next[idx] = 1'b1;
                        if (access.address == srb_pkg::ADDR_SWEEP)
                        begin
                            res_next.update_kind  = srb_pkg::KIND_SWEEP;
                            res_next.ramp_up      = !access.value[3];
                            res_next.ramp_step    = access.value[2:0];
                            res_next.sweep_period = access.value[6:4];
                        end
                        else if ((access.address == srb_pkg::ADDR_TONE0_HI
                                  || access.address == srb_pkg::ADDR_TONE1_HI)
                                 && access.value[7])
                        begin
                            // trigger: fetch pattern, volume and low frequency
                            chan_next  = access.address == srb_pkg::ADDR_TONE1_HI;
                            base_next  = chan_next ? IDX_PAT1 : IDX_PAT0;
                            hi_next    = access.value;
                            raddr      = base_next;
                            state_next = srb_pkg::ST_PAT;
                        end
                    end
                end
            end
            srb_pkg::ST_READ:
            begin
                res_next.read_data = rd_byte;
                state_next         = srb_pkg::ST_HOLD;
            end
            srb_pkg::ST_PAT:
            begin
                pat_next   = rd_byte;
                raddr      = IW'(base_reg + 1'b1);
                state_next = srb_pkg::ST_VOL;
            end
            srb_pkg::ST_VOL:
            begin
                vol_next   = rd_byte;
                raddr      = IW'(base_reg + 2'd2);
                state_next = srb_pkg::ST_LO;
            end
            srb_pkg::ST_LO:
            begin
                div_start  = 1'b1;
                state_next = srb_pkg::ST_DIV;
            end
            srb_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    res_next.update_kind  = srb_pkg::KIND_TRIGGER;
                    res_next.channel      = chan_reg;
                    res_next.length_on    = hi_reg[6];
                    res_next.length_left  = hi_reg[6]
                                            ? 7'(srb_pkg::LEN_FULL - {1'b0, pat_reg[5:0]})
                                            : 7'd0;
                    res_next.frequency_hz = (div_quo > srb_pkg::FREQ_LIMIT)
                                            ? 12'd0 : div_quo[11:0];
                    res_next.duty_code    = pat_reg[7:6];
                    res_next.start_volume = vol_reg[7:4];
                    res_next.ramp_up      = vol_reg[3];
                    res_next.ramp_step    = vol_reg[2:0];
                    res_next.sweep_period = 3'd0;
                    state_next            = srb_pkg::ST_HOLD;
                end
            end
            srb_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    out_vld_next = 1'b1;
                    state_next   = srb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srb_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= srb_pkg::ST_IDLE;
            out_vld_reg <= 1'b0;
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            vld_reg     <= vld_next;
            rd_vld_reg  <= vld_reg[raddr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        hi_reg   <= hi_next;
        chan_reg <= chan_next;
        pat_reg  <= pat_next;
        vol_reg  <= vol_next;
        base_reg <= base_next;
        if (state_reg == srb_pkg::ST_HOLD && out_free)
        begin
            out_reg <= res_reg;
        end
    end

    srb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (idx),
        .wdata (access.value),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    srb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (srb_pkg::FREQ_NUM),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

endmodule

// ===== sv/srb_checker.sv =====
// port-level checks for the sound register block, bound to the top level
module srb_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             access_valid,
    input logic             access_stall,
    input srb_pkg::access_t access,
    input logic             result_valid,
    input logic             result_stall,
    input srb_pkg::result_t result
);

    // a stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result item changed");

    // one item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        access_valid && !access_stall |=> access_stall)
        else $error("item accepted while previous item in work");

    // a bad address gives no data and no command
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.bad_address
        |-> result.read_data == 8'h00 && result.update_kind == srb_pkg::KIND_NONE)
        else $error("bad address item carries data or command");

    // commands come only from writes
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.update_kind != srb_pkg::KIND_NONE
        |-> result.read_data == 8'h00 && !result.bad_address)
        else $error("command item carries read data");

    // sweep commands leave trigger fields clear
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.update_kind == srb_pkg::KIND_SWEEP
        |-> result.frequency_hz == 12'd0 && !result.channel && !result.length_on)
        else $error("sweep command carries trigger fields");

endmodule

bind sound_register_block_with_tone_trigger_core srb_checker u_srb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .access_valid (access_valid),
    .access_stall (access_stall),
    .access       (access),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ===== dv/sound_register_block_with_tone_trigger_core_test.sv =====
// testbench for the sound register block: directed and random bus accesses checked by a predictor
module sound_register_block_with_tone_trigger_core_test;

    // run limits
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int BANK_BYTES      = srb_pkg::WAVE_BASE + 16;
    localparam int TONE0_PAT_SLOT  = 1;
    localparam int TONE1_PAT_SLOT  = 5;
    localparam int TONE1_LO_SLOT   = 5;
    localparam int PLAIN_C_SLOT    = srb_pkg::TONE_SLOTS + 5;
    localparam int LONG_HOLD       = 300;
    localparam logic [15:0] PROBE_WINDOW = 16'hff00;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             access_valid = 1'b0;
    logic             access_stall;
    srb_pkg::access_t access = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    srb_pkg::result_t result;

    // bank copy kept by the predictor, and the queues between processes
    logic [7:0]       bank_copy [BANK_BYTES] = '{default: 8'h00};
    srb_pkg::access_t queued_accesses [$];
    srb_pkg::result_t pending_replies [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles_left = 0;
    int items_sent = 0;
    int failures = 0;
    int quiet_cycles = 0;

    sound_register_block_with_tone_trigger_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .access_valid (access_valid),
        .access_stall (access_stall),
        .access       (access),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // bus address to bank slot, -1 when not a handled register
    function automatic int slot_of(logic [15:0] addr);
        if (addr >= srb_pkg::ADDR_TONE0_LO && addr <= srb_pkg::ADDR_TONE0_HI)
            return int'(addr - srb_pkg::ADDR_TONE0_LO);
        if (addr >= srb_pkg::ADDR_TONE1_LO && addr <= srb_pkg::ADDR_TONE1_HI)
            return TONE1_LO_SLOT + int'(addr - srb_pkg::ADDR_TONE1_LO);
        if (addr >= srb_pkg::ADDR_PLAIN_A && addr <= srb_pkg::ADDR_PLAIN_B)
            return srb_pkg::TONE_SLOTS + int'(addr - srb_pkg::ADDR_PLAIN_A);
        if (addr >= srb_pkg::ADDR_PLAIN_C && addr <= srb_pkg::ADDR_PLAIN_D)
            return PLAIN_C_SLOT + int'(addr - srb_pkg::ADDR_PLAIN_C);
        if (addr >= srb_pkg::ADDR_WAVE && addr <= srb_pkg::ADDR_WAVE_END)
            return srb_pkg::WAVE_BASE + int'(addr - srb_pkg::ADDR_WAVE);
        return -1;
    endfunction

    // bank slot back to its bus address
    function automatic logic [15:0] address_of_slot(int slot);
        if (slot < TONE1_LO_SLOT)
            return srb_pkg::ADDR_TONE0_LO + 16'(slot);
        if (slot < srb_pkg::TONE_SLOTS)
            return srb_pkg::ADDR_TONE1_LO + 16'(slot - TONE1_LO_SLOT);
        if (slot < PLAIN_C_SLOT)
            return srb_pkg::ADDR_PLAIN_A + 16'(slot - srb_pkg::TONE_SLOTS);
        if (slot < srb_pkg::WAVE_BASE)
            return srb_pkg::ADDR_PLAIN_C + 16'(slot - PLAIN_C_SLOT);
        return srb_pkg::ADDR_WAVE + 16'(slot - srb_pkg::WAVE_BASE);
    endfunction

    // expected reply for one access, updating the bank copy on writes
    function automatic srb_pkg::result_t predict_bus_access(srb_pkg::access_t a);
        srb_pkg::result_t r;
        int               slot;
        int               base;
        int               hz;
        logic [7:0]       pattern;
        logic [7:0]       volume;
        logic [7:0]       hi;
        logic [10:0]      period;
        r = '0;
        slot = slot_of(a.address);
        if (slot < 0)
        begin
            r.bad_address = 1'b1;
            return r;
        end
        if (a.op == srb_pkg::OP_READ)
        begin
            r.read_data = bank_copy[slot];
            return r;
        end
        bank_copy[slot] = a.value;
        if (a.address == srb_pkg::ADDR_SWEEP)
        begin
            // sweep direction is rising when bit 3 is clear
            r.update_kind  = srb_pkg::KIND_SWEEP;
            r.ramp_up      = ~a.value[3];
            r.ramp_step    = a.value[2:0];
            r.sweep_period = a.value[6:4];
        end
        else if ((a.address == srb_pkg::ADDR_TONE0_HI || a.address == srb_pkg::ADDR_TONE1_HI)
                 && a.value[7])
        begin
            base    = (a.address == srb_pkg::ADDR_TONE1_HI) ? TONE1_PAT_SLOT : TONE0_PAT_SLOT;
            pattern = bank_copy[base];
            volume  = bank_copy[base + 1];
            hi      = bank_copy[base + 3];
            period  = {hi[2:0], bank_copy[base + 2]};
            hz      = int'(srb_pkg::FREQ_NUM) / (int'(srb_pkg::FREQ_BASE) - int'(period));
            r.update_kind  = srb_pkg::KIND_TRIGGER;
            r.channel      = (base == TONE1_PAT_SLOT);
            r.length_on    = hi[6];
            r.length_left  = hi[6] ? srb_pkg::LEN_FULL - {1'b0, pattern[5:0]} : 7'd0;
            r.frequency_hz = (hz > int'(srb_pkg::FREQ_LIMIT)) ? 12'd0 : hz[11:0];
            r.duty_code    = pattern[7:6];
            r.start_volume = volume[7:4];
            r.ramp_up      = volume[3];
            r.ramp_step    = volume[2:0];
        end
        return r;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // sender: presents queued items, holds a stalled item, idles at random
    always @(posedge clk)
    begin
        if (access_valid && !access_stall)
            void'(queued_accesses.pop_front());
        if (!access_valid || !access_stall)
        begin
            if (queued_accesses.size() != 0 && int'($urandom_range(99)) >= send_idle_pct)
            begin
                access_valid <= 1'b1;
                access       <= queued_accesses[0];
            end
            else
                access_valid <= 1'b0;
        end
    end

    // receiver: long hold when asked, otherwise random stalls
    always @(posedge clk)
    begin
        if (hold_cycles_left > 0)
        begin
            result_stall <= 1'b1;
            hold_cycles_left--;
        end
        else
            result_stall <= (int'($urandom_range(99)) < recv_idle_pct);
    end

    // predict each accepted item, check each accepted result
    always @(posedge clk)
    begin
        srb_pkg::result_t want;
        if (rst_n)
        begin
            if (access_valid && !access_stall)
                pending_replies.push_back(predict_bus_access(access));
            if (result_valid && !result_stall)
            begin
                if (pending_replies.size() == 0)
                begin
                    $error("result %h with no item outstanding", result);
                    failures++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    compare_field("read_data", want.read_data, result.read_data);
                    compare_field("bad_address", want.bad_address, result.bad_address);
                    compare_field("update_kind", want.update_kind, result.update_kind);
                    compare_field("channel", want.channel, result.channel);
                    compare_field("length_on", want.length_on, result.length_on);
                    compare_field("length_left", want.length_left, result.length_left);
                    compare_field("frequency_hz", want.frequency_hz, result.frequency_hz);
                    compare_field("duty_code", want.duty_code, result.duty_code);
                    compare_field("start_volume", want.start_volume, result.start_volume);
                    compare_field("ramp_up", want.ramp_up, result.ramp_up);
                    compare_field("ramp_step", want.ramp_step, result.ramp_step);
                    compare_field("sweep_period", want.sweep_period, result.sweep_period);
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (!rst_n || (access_valid && !access_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // queue one item, keeping at most two ahead of the bus
    task automatic send_access(input logic op, input logic [15:0] addr, input logic [7:0] val);
        srb_pkg::access_t a;
        a.op      = op;
        a.address = addr;
        a.value   = val;
        while (queued_accesses.size() >= 2)
            @(posedge clk);
        queued_accesses.push_back(a);
        items_sent++;
    endtask

    task automatic wait_drained();
        while (queued_accesses.size() != 0 || access_valid || pending_replies.size() != 0)
            @(posedge clk);
    endtask

    // registers read as zero after reset
    task automatic test_reset_values();
        send_access(srb_pkg::OP_READ, srb_pkg::ADDR_SWEEP, 8'h00);
        send_access(srb_pkg::OP_READ, srb_pkg::ADDR_WAVE_END, 8'hff);
    endtask

    // addresses just after the first tone range and the first plain range, and the bus extremes
    task automatic test_bad_addresses();
        send_access(srb_pkg::OP_READ, srb_pkg::ADDR_TONE0_HI + 16'd1, 8'h00);
        send_access(srb_pkg::OP_WRITE, srb_pkg::ADDR_PLAIN_B + 16'd1, 8'hff);
        send_access(srb_pkg::OP_READ, '0, 8'h00);
        send_access(srb_pkg::OP_WRITE, '1, 8'hff);
    endtask

    // sweep commands in both directions
    task automatic test_sweep_commands();
        send_access(srb_pkg::OP_WRITE, srb_pkg::ADDR_SWEEP, 8'hff);
        send_access(srb_pkg::OP_WRITE, srb_pkg::ADDR_SWEEP, 8'h00);
        send_access(srb_pkg::OP_READ, srb_pkg::ADDR_SWEEP, 8'h00);
    endtask

    // triggers on both channels: top period, frequency limit edge, length off
    task automatic test_tone_triggers();
        send_access(srb_pkg::OP_WRITE, srb_pkg::ADDR_TONE0_LO + 16'd1, 8'hff);
        send_access(srb_pkg::OP_WRITE, srb_pkg::ADDR_TONE0_LO + 16'd2, 8'hf8);
        send_access(srb_pkg::OP_WRITE, srb_pkg::ADDR_TONE0_LO + 16'd3, 8'hff);
        send_access(srb_pkg::OP_WRITE, srb_pkg::ADDR_TONE0_HI, 8'hc7);
        // highest period still under the frequency limit, then just over it
        send_access(srb_pkg::OP_WRITE, srb_pkg::ADDR_TONE0_LO + 16'd3, 8'hd4);
        send_access(srb_pkg::OP_WRITE, srb_pkg::ADDR_TONE0_HI, 8'h87);
        send_access(srb_pkg::OP_WRITE, srb_pkg::ADDR_TONE0_LO + 16'd3, 8'hd5);
        send_access(srb_pkg::OP_WRITE, srb_pkg::ADDR_TONE0_HI, 8'h87);
        // second channel, lowest period and full length
        send_access(srb_pkg::OP_WRITE, srb_pkg::ADDR_TONE1_LO, 8'h00);
        send_access(srb_pkg::OP_WRITE, srb_pkg::ADDR_TONE1_LO + 16'd1, 8'h07);
        send_access(srb_pkg::OP_WRITE, srb_pkg::ADDR_TONE1_LO + 16'd2, 8'h00);
        send_access(srb_pkg::OP_WRITE, srb_pkg::ADDR_TONE1_HI, 8'hc0);
        // high register write without the trigger bit
        send_access(srb_pkg::OP_WRITE, srb_pkg::ADDR_TONE1_HI, 8'h40);
    endtask

    // plain channel and wave table store and read back
    task automatic test_plain_and_wave();
        send_access(srb_pkg::OP_WRITE, srb_pkg::ADDR_PLAIN_A, 8'haa);
        send_access(srb_pkg::OP_READ, srb_pkg::ADDR_PLAIN_A, 8'h00);
        send_access(srb_pkg::OP_WRITE, srb_pkg::ADDR_WAVE_END, 8'h55);
        send_access(srb_pkg::OP_READ, srb_pkg::ADDR_WAVE_END, 8'h00);
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        int i;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles_left = LONG_HOLD;
        for (i = 0; i < 12; i++)
            send_access(1'($urandom_range(1)),
                        address_of_slot(int'($urandom_range(BANK_BYTES - 1))),
                        8'($urandom));
        send_access(srb_pkg::OP_WRITE, srb_pkg::ADDR_TONE1_HI, 8'h80);
        wait_drained();
    endtask

    // random traffic, mostly well-formed trigger setups and register accesses
    task automatic test_random(input int count, input int send_pct, input int recv_pct);
        int         start_count;
        int         pick;
        int         base;
        logic [7:0] lo;
        logic [7:0] hi;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start_count = items_sent;
        while (items_sent - start_count < count)
        begin
            pick = int'($urandom_range(99));
            if (pick < 25)
            begin
                // full setup of one tone channel ending in its high register
                base = ($urandom_range(1) != 0) ? TONE1_PAT_SLOT : TONE0_PAT_SLOT;
                lo = 8'($urandom);
                hi = 8'($urandom);
                if ($urandom_range(4) == 0)
                begin
                    hi[2:0] = 3'd7;
                    lo = 8'($urandom_range(255, 192));
                end
                hi[7] = ($urandom_range(7) != 0);
                send_access(srb_pkg::OP_WRITE, address_of_slot(base), 8'($urandom));
                send_access(srb_pkg::OP_WRITE, address_of_slot(base + 1), 8'($urandom));
                send_access(srb_pkg::OP_WRITE, address_of_slot(base + 2), lo);
                send_access(srb_pkg::OP_WRITE, address_of_slot(base + 3), hi);
            end
            else if (pick < 35)
                send_access(srb_pkg::OP_WRITE, srb_pkg::ADDR_SWEEP, 8'($urandom));
            else if (pick < 75)
                send_access(1'($urandom_range(1)),
                            address_of_slot(int'($urandom_range(BANK_BYTES - 1))),
                            8'($urandom));
            else if (pick < 88)
                send_access(1'($urandom_range(1)), PROBE_WINDOW + 16'($urandom_range(127)),
                            8'($urandom));
            else
                send_access(1'($urandom_range(1)), 16'($urandom), 8'($urandom));
        end
    endtask

    // test sequence
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 32;
        recv_idle_pct = 45;
        test_reset_values();
        test_bad_addresses();
        test_sweep_commands();
        test_tone_triggers();
        test_plain_and_wave();
        test_backpressure();
        test_random(600, 32, 45);
        test_random(600, 45, 32);
        test_random(600, 0, 0);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && pending_replies.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
